[rtl/core/emrt_pkg.sv]
package emrt_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 64;
    localparam int NODE_ID_BITS = 16;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // request kinds
    localparam logic FUNC_MAKE = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    // result codes
    localparam int STAT_W = 3;
    localparam logic [STAT_W-1:0] STAT_FOUND = 3'd0;
    localparam logic [STAT_W-1:0] STAT_MISS = 3'd1;
    localparam logic [STAT_W-1:0] STAT_INSERTED = 3'd2;
    localparam logic [STAT_W-1:0] STAT_UPDATED = 3'd3;
    localparam logic [STAT_W-1:0] STAT_FULL = 3'd4;

    typedef logic [NODE_ID_BITS-1:0] t_node;

    // one stored route
    typedef struct packed {
        t_node src;
        t_node dst;
        t_node next_hop;
    } t_entry;

    // one request item
    typedef struct packed {
        logic  func;
        t_node src;
        t_node dst;
        t_node next_hop;
    } t_req;

    // table write port
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_entry           data;
    } t_mem_wr;

    // result handed to the output stage
    typedef struct packed {
        logic              valid;
        t_node             hop;
        logic [STAT_W-1:0] status;
    } t_result;

endpackage

[rtl/core/emrt_mem.sv]
module emrt_mem (
    input  logic                     i_clk,
    input  emrt_pkg::t_mem_wr        i_wr,
    input  logic [emrt_pkg::IDX_W-1:0] i_rd_addr,
    output emrt_pkg::t_entry         o_rd_data
);
    import emrt_pkg::*;

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd_data;

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/emrt_ctrl.sv]
module emrt_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_req_valid,
    output logic                       o_req_ready,
    input  emrt_pkg::t_req             i_req,
    output logic [emrt_pkg::IDX_W-1:0] o_rd_addr,
    input  emrt_pkg::t_entry           i_rd_data,
    output emrt_pkg::t_mem_wr          o_wr,
    output emrt_pkg::t_result          o_res,
    input  logic                       i_res_ready
);
    import emrt_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]        r_state, n_state;
    t_req              r_req, n_req;
    logic [IDX_W-1:0]  r_addr, n_addr;
    logic [CNT_W-1:0]  r_count, n_count;
    t_node             r_hop, n_hop;
    logic [STAT_W-1:0] r_status, n_status;

    logic [CNT_W-1:0]  addr_next;
    logic              accept;
    logic              finish;
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    t_node             hit_nh;
    t_req              key;

    assign accept = i_req_valid && (r_state == S_IDLE);
    assign o_req_ready = (r_state == S_IDLE);
    assign addr_next = CNT_W'(r_addr) + CNT_W'(1);

    // read address: entry 0 on accept, then the one after the entry being compared
    assign o_rd_addr = (r_state == S_IDLE) ? '0 : addr_next[IDX_W-1:0];

    // search sequencer and table update
    always_comb begin
        n_state = r_state;
        n_req = r_req;
        n_addr = r_addr;
        n_count = r_count;
        n_hop = r_hop;
        n_status = r_status;
        finish = 1'b0;
        hit = 1'b0;
        hit_idx = '0;
        hit_nh = '0;
        key = (r_state == S_IDLE) ? i_req : r_req;
        o_wr = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_req = i_req;
                    n_addr = '0;
                    if (i_req.func == FUNC_LOOKUP && i_req.src == i_req.dst) begin
                        // route to self, table not searched
                        n_hop = i_req.src;
                        n_status = STAT_FOUND;
                        n_state = S_DONE;
                    end else if (r_count == '0) begin
                        finish = 1'b1;
                    end else begin
                        n_state = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (i_rd_data.src == r_req.src && i_rd_data.dst == r_req.dst) begin
                    hit = 1'b1;
                    hit_idx = r_addr;
                    hit_nh = i_rd_data.next_hop;
                    finish = 1'b1;
                end else if (addr_next == r_count) begin
                    finish = 1'b1;
                end else begin
                    n_addr = addr_next[IDX_W-1:0];
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // end of search: form result, at most one write-back
        if (finish) begin
            n_state = S_DONE;
            n_hop = '0;
            if (key.func == FUNC_LOOKUP) begin
                n_status = hit ? STAT_FOUND : STAT_MISS;
                n_hop = hit ? hit_nh : '0;
            end else if (hit) begin
                n_status = STAT_UPDATED;
                o_wr.en = 1'b1;
                o_wr.addr = hit_idx;
                o_wr.data = '{src: key.src, dst: key.dst, next_hop: key.next_hop};
            end else if (r_count < CNT_W'(TABLE_DEPTH)) begin
                n_status = STAT_INSERTED;
                o_wr.en = 1'b1;
                o_wr.addr = r_count[IDX_W-1:0];
                o_wr.data = '{src: key.src, dst: key.dst, next_hop: key.next_hop};
                n_count = r_count + CNT_W'(1);
            end else begin
                n_status = STAT_FULL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_addr <= n_addr;
        r_hop <= n_hop;
        r_status <= n_status;
    end

    assign o_res = '{valid: (r_state == S_DONE), hop: r_hop, status: r_status};

endmodule

[rtl/core/exact_match_route_table_top.sv]
// Exact-match route table keyed by a (source, destination) pair, up to TABLE_DEPTH
// routes held in one single-port-write, registered-read memory and filled in order,
// so a fill count marks the live entries and no clearing pass is needed after reset.
// One item is processed at a time: a lookup of a node to itself answers without
// searching the table; any other item scans the live entries one per cycle through
// the memory read port, stopping at the first match. The write-back of a make-route
// lands before the next item's first read, so entries never need forwarding. A
// finished result sits in the output register while the next item is taken.
module exact_match_route_table_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,  // src_node[15:0], dst_node[31:16], next_hop_in[47:32]
    input  logic [0:0]  i_s_tuser,  // func[0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,  // next_hop_out[15:0]
    output logic [2:0]  o_m_tuser   // status[2:0]
);
    import emrt_pkg::*;

    t_req              req;
    logic [IDX_W-1:0]  rd_addr;
    t_entry            rd_data;
    t_mem_wr           wr;
    t_result           res;
    logic              res_ready;
    logic              r_out_valid;
    t_node             r_out_hop;
    logic [STAT_W-1:0] r_out_status;

    // unpack the input item
    assign req = '{func: i_s_tuser[0],
                   src: i_s_tdata[15:0],
                   dst: i_s_tdata[31:16],
                   next_hop: i_s_tdata[47:32]};

    emrt_mem u_mem (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    emrt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_tvalid),
        .o_req_ready (o_s_tready),
        .i_req       (req),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_wr        (wr),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    // output register
    assign res_ready = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid && res_ready) begin
            r_out_hop <= res.hop;
            r_out_status <= res.status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata = r_out_hop;
    assign o_m_tuser = r_out_status;

    // busy after an item is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input taken while an item is in flight");

    // no table writes in a row, as each item writes back at most once
    a_single_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr.en |=> !wr.en)
        else $error("table written on consecutive cycles");

    // only a found lookup carries a next hop
    a_hop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res.valid && res.status != STAT_FOUND) |-> (res.hop == '0))
        else $error("nonzero next hop without a hit");

    // no input is taken while a result is pending
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.valid |-> !o_s_tready)
        else $error("result pending while accepting input");

endmodule
